// ===== hw/rtl/mrac_pkg.sv =====
package mrac_pkg;

   localparam int CMD_W    = 3;
   localparam int ID_W     = 16;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 3;
   localparam int PHYS_W   = ADDR_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_DEFINE = 3'd0,
      CMD_CLEAR  = 3'd1,
      CMD_READ   = 3'd2,
      CMD_WRITE  = 3'd3,
      CMD_FIND   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_UNDEF    = 3'd1,
      STATUS_NOREAD   = 3'd2,
      STATUS_NOWRITE  = 3'd3,
      STATUS_BOUNDARY = 3'd4,
      STATUS_NOAREA   = 3'd5,
      STATUS_FULL     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
      logic              readable;
      logic              writable;
   } slot_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_status_type;

endpackage

// ===== hw/rtl/mrac_channels.sv =====
interface mrac_req_if;
   import mrac_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ID_W-1:0]   region_id;
   logic [ADDR_W-1:0] base_or_lookup_address;
   logic [ADDR_W-1:0] access_offset;
   logic [ADDR_W-1:0] length;
   logic              allow_read;
   logic              allow_write;

   modport source (
      output valid, command, region_id, base_or_lookup_address, access_offset, length,
      output allow_read, allow_write,
      input  ready
   );

   modport sink (
      input  valid, command, region_id, base_or_lookup_address, access_offset, length,
      input  allow_read, allow_write,
      output ready
   );
endinterface

interface mrac_rsp_if;
   import mrac_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                hit;
   logic [ID_W-1:0]     found_id;
   logic [PHYS_W-1:0]   physical_address;

   modport source (
      output valid, status, hit, found_id, physical_address,
      input  ready
   );

   modport sink (
      input  valid, status, hit, found_id, physical_address,
      output ready
   );
endinterface

// ===== hw/rtl/memory_region_access_checker.sv =====
// Memory region access checker: a table of AREA_SLOTS areas (id, start, size, read and
// write permission) answers one command per item with one result item. Define, check read,
// check write and find scan the table through its single read port, one slot per cycle, then
// pass a last step and a finish step before the next acceptance; clear all and unknown
// commands go straight to the finish step. A finished result waits in an output register,
// and the next item is accepted while it waits.
// Slot valid bits are cleared by reset; no clearing pass is needed.
module memory_region_access_checker #(
   parameter int AREA_SLOTS = 16
) (
   input logic        clock,
   input logic        reset,
   mrac_req_if.sink   req_chan,
   mrac_rsp_if.source rsp_chan
);
   import mrac_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mrac_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   mrac_datapath #(
      .AREA_SLOTS (AREA_SLOTS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_command          (req_chan.command),
      .req_region_id        (req_chan.region_id),
      .req_address          (req_chan.base_or_lookup_address),
      .req_offset           (req_chan.access_offset),
      .req_length           (req_chan.length),
      .req_allow_read       (req_chan.allow_read),
      .req_allow_write      (req_chan.allow_write),
      .dp_cmd               (dp_cmd),
      .dp_status            (dp_status),
      .rsp_status           (rsp_chan.status),
      .rsp_hit              (rsp_chan.hit),
      .rsp_found_id         (rsp_chan.found_id),
      .rsp_physical_address (rsp_chan.physical_address)
   );
endmodule

// ===== hw/rtl/mrac_ram.sv =====
module mrac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/mrac_ctrl.sv =====
module mrac_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [mrac_pkg::CMD_W-1:0]    req_command,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mrac_pkg::dp_cmd_type          dp_cmd,
   input  mrac_pkg::dp_status_type       dp_status
);
   import mrac_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command inside {CMD_DEFINE, CMD_READ, CMD_WRITE, CMD_FIND}) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (dp_status.scan_last) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      dp_cmd.load   = 1'b0;
      dp_cmd.issue  = 1'b0;
      dp_cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
         end
         ST_SCAN: begin
            dp_cmd.issue = 1'b1;
         end
         ST_LAST: begin
         end
         ST_FINISH: begin
            dp_cmd.finish = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = dp_cmd.finish || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== hw/rtl/mrac_datapath.sv =====
module mrac_datapath #(
   parameter int AREA_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mrac_pkg::CMD_W-1:0]      req_command,
   input  logic [mrac_pkg::ID_W-1:0]       req_region_id,
   input  logic [mrac_pkg::ADDR_W-1:0]     req_address,
   input  logic [mrac_pkg::ADDR_W-1:0]     req_offset,
   input  logic [mrac_pkg::ADDR_W-1:0]     req_length,
   input  logic                            req_allow_read,
   input  logic                            req_allow_write,
   input  mrac_pkg::dp_cmd_type            dp_cmd,
   output mrac_pkg::dp_status_type         dp_status,
   output logic [mrac_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_hit,
   output logic [mrac_pkg::ID_W-1:0]       rsp_found_id,
   output logic [mrac_pkg::PHYS_W-1:0]     rsp_physical_address
);
   import mrac_pkg::*;

   localparam int IDX_W  = (AREA_SLOTS > 1) ? $clog2(AREA_SLOTS) : 1;
   localparam int SLOT_W = $bits(slot_type);

   logic [CMD_W-1:0]  cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] off_ff;
   logic [ADDR_W-1:0] len_ff;
   logic              rd_ff;
   logic              wr_ff;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              eval_ff;
   logic [IDX_W-1:0]  eval_idx_ff;
   logic [AREA_SLOTS-1:0] valid_ff, valid_in;

   logic              match_found_ff, match_found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   slot_type          match_slot_ff, match_slot_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              best_found_ff, best_found_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [ADDR_W-1:0] best_start_ff, best_start_in;

   logic [SLOT_W-1:0] rd_data;
   slot_type          entry;
   logic              ent_valid;
   logic [PHYS_W-1:0] ent_end;
   logic              id_hit, is_free, contains, better;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   slot_type          ram_wr_data;

   logic [PHYS_W-1:0]   access_end;
   logic [PHYS_W-1:0]   phys_sum;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                hit_ff, hit_in;
   logic [ID_W-1:0]     fid_ff, fid_in;
   logic [PHYS_W-1:0]   phys_ff, phys_in;

   mrac_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (AREA_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (dp_cmd.issue),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign dp_status.scan_last = (idx_ff == IDX_W'(AREA_SLOTS - 1));

   always_comb begin
      idx_in = idx_ff;
      if (dp_cmd.load) begin
         idx_in = '0;
      end else if (dp_cmd.issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   assign entry     = slot_type'(rd_data);
   assign ent_valid = valid_ff[eval_idx_ff];
   assign ent_end   = {1'b0, entry.start} + {1'b0, entry.size};
   assign id_hit    = eval_ff && ent_valid && (entry.id == id_ff);
   assign is_free   = eval_ff && !ent_valid;
   assign contains  = eval_ff && ent_valid && (addr_ff >= entry.start)
                      && ({1'b0, addr_ff} < ent_end);
   assign better    = contains && (!best_found_ff || (entry.id < best_id_ff));

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_slot_in  = match_slot_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_found_in  = best_found_ff;
      best_id_in     = best_id_ff;
      best_start_in  = best_start_ff;
      if (dp_cmd.load) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         best_found_in  = 1'b0;
      end else begin
         if (id_hit) begin
            match_found_in = 1'b1;
            match_idx_in   = eval_idx_ff;
            match_slot_in  = entry;
         end
         if (is_free && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = eval_idx_ff;
         end
         if (better) begin
            best_found_in = 1'b1;
            best_id_in    = entry.id;
            best_start_in = entry.start;
         end
      end
   end

   assign ram_wr_en   = dp_cmd.finish && (cmd_ff == CMD_DEFINE)
                        && (match_found_ff || free_found_ff);
   assign ram_wr_addr = match_found_ff ? match_idx_ff : free_idx_ff;
   always_comb begin
      ram_wr_data.id       = id_ff;
      ram_wr_data.start    = addr_ff;
      ram_wr_data.size     = len_ff;
      ram_wr_data.readable = rd_ff;
      ram_wr_data.writable = wr_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      if (dp_cmd.finish && (cmd_ff == CMD_CLEAR)) begin
         valid_in = '0;
      end else if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   assign access_end = {1'b0, off_ff} + {1'b0, len_ff};
   assign phys_sum   = {1'b0, match_slot_ff.start} + {1'b0, off_ff};

   always_comb begin
      status_in = STATUS_OK;
      hit_in    = 1'b0;
      fid_in    = '0;
      phys_in   = '0;
      case (cmd_ff)
         CMD_DEFINE: begin
            if (match_found_ff || free_found_ff) begin
               hit_in = match_found_ff;
               fid_in = id_ff;
            end else begin
               status_in = STATUS_FULL;
            end
         end
         CMD_CLEAR: begin
         end
         CMD_READ, CMD_WRITE: begin
            if (!match_found_ff) begin
               status_in = STATUS_UNDEF;
            end else begin
               hit_in = 1'b1;
               fid_in = id_ff;
               if ((cmd_ff == CMD_READ) && !match_slot_ff.readable) begin
                  status_in = STATUS_NOREAD;
               end else if ((cmd_ff == CMD_WRITE) && !match_slot_ff.writable) begin
                  status_in = STATUS_NOWRITE;
               end else if (access_end > {1'b0, match_slot_ff.size}) begin
                  status_in = STATUS_BOUNDARY;
               end else begin
                  phys_in = phys_sum;
               end
            end
         end
         CMD_FIND: begin
            if (best_found_ff) begin
               hit_in  = 1'b1;
               fid_in  = best_id_ff;
               phys_in = {1'b0, best_start_ff};
            end else begin
               status_in = STATUS_NOAREA;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         eval_ff        <= 1'b0;
         valid_ff       <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_found_ff  <= 1'b0;
      end else begin
         idx_ff         <= idx_in;
         eval_ff        <= dp_cmd.issue;
         valid_ff       <= valid_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         best_found_ff  <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff   <= idx_ff;
      match_idx_ff  <= match_idx_in;
      match_slot_ff <= match_slot_in;
      free_idx_ff   <= free_idx_in;
      best_id_ff    <= best_id_in;
      best_start_ff <= best_start_in;
      if (dp_cmd.load) begin
         cmd_ff  <= req_command;
         id_ff   <= req_region_id;
         addr_ff <= req_address;
         off_ff  <= req_offset;
         len_ff  <= req_length;
         rd_ff   <= req_allow_read;
         wr_ff   <= req_allow_write;
      end
      if (dp_cmd.finish) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
         fid_ff    <= fid_in;
         phys_ff   <= phys_in;
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_found_id         = fid_ff;
   assign rsp_physical_address = phys_ff;
endmodule
